>>> sv/local_mean_threshold_3x3_core_defines.svh
// assertion macros shared by the local mean threshold checker
`ifndef LOCAL_MEAN_THRESHOLD_3X3_CORE_DEFINES_SVH
`define LOCAL_MEAN_THRESHOLD_3X3_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define LMT3_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LMT3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/lmt3_pkg.sv
// shared types, constants and helper functions of the local mean threshold core
`default_nettype none

package lmt3_pkg;

   // image geometry
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
   localparam int SIZE_BITS  = 13;

   // sample and neighborhood sum widths (nine samples at most)
   localparam int PIXEL_BITS = 16;
   localparam int CNT_BITS   = 4;
   localparam int SUM_BITS   = PIXEL_BITS + CNT_BITS;

   // result buffer, up to four results per input word
   localparam int RES_MAX      = 4;
   localparam int RES_IDX_BITS = $clog2(RES_MAX);
   localparam int RES_CNT_BITS = RES_IDX_BITS + 1;

   // register map
   localparam int CSR_INDEX_BITS = 1;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   localparam csr_index_type REG_IMAGE_WIDTH  = 1'b0;
   localparam csr_index_type REG_IMAGE_HEIGHT = 1'b1;

   typedef logic [COL_BITS-1:0]     col_type;
   typedef logic [ROW_BITS-1:0]     row_type;
   typedef logic [SIZE_BITS-1:0]    size_type;
   typedef logic [PIXEL_BITS-1:0]   pix_type;
   typedef logic [SUM_BITS-1:0]     sum_type;
   typedef logic [CNT_BITS-1:0]     cnt_type;
   typedef logic [RES_CNT_BITS-1:0] res_cnt_type;

   // three rows of one window column, index is the row
   typedef pix_type [2:0] col3_type;
   // window indexed [row][col], rows r-2..r, columns c-2..c
   typedef pix_type [2:0][2:0] win_type;
   // one line store entry: {row r-2 sample, row r-1 sample}
   typedef logic [2*PIXEL_BITS-1:0] line_word_type;

   typedef struct packed {
      logic    above_mean;
      row_type out_row;
      col_type out_col;
      logic    run_last;
      logic    frame_done;
   } res_type;

   typedef res_type [RES_MAX-1:0] res_vec_type;

   localparam size_type MAX_WIDTH_SIZE  = size_type'(MAX_WIDTH);
   localparam size_type MAX_HEIGHT_SIZE = size_type'(MAX_HEIGHT);
   localparam col_type  WIDTH_M1_RESET  = col_type'(63);
   localparam row_type  HEIGHT_M1_RESET = row_type'(63);

   // size register value minus one, zero taken as one, large values saturated
   function automatic size_type size_m1(input size_type v, input size_type max_size);
      size_type res;
      if (v == '0) begin
         res = '0;
      end else if (v > max_size) begin
         res = size_type'(max_size - size_type'(1));
      end else begin
         res = size_type'(v - size_type'(1));
      end
      return res;
   endfunction

   // compare center times neighbor count against the masked neighborhood sum
   function automatic logic judge(input win_type win, input logic [2:0] row_ok,
                                  input logic [2:0] col_ok, input logic [1:0] ci,
                                  input logic [1:0] cj);
      sum_type sum;
      cnt_type cnt;
      sum_type prod;
      sum = '0;
      cnt = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (row_ok[i] && col_ok[j]) begin
               sum = sum_type'(sum + sum_type'(win[i][j]));
               cnt = cnt_type'(cnt + cnt_type'(1));
            end
         end
      end
      prod = sum_type'(sum_type'(win[ci][cj]) * sum_type'(cnt));
      return prod > sum;
   endfunction

endpackage

`default_nettype wire

>>> sv/local_mean_threshold_3x3_core.sv
// top level of the streaming 3x3 local mean threshold core
// Pixels of an image_width by image_height frame enter in row-major order, one
// word per clock when the result side keeps up. Each pixel's result leaves one
// row plus one pixel later, so the last pixel of every row after the first
// releases two results, as does each pixel but the first of a frame's last row,
// and the final pixel releases four; during those bursts the input stalls while
// the result buffer drains, one word per clock while rsp_stall is low. An
// accepted word is held in the input stage register, its results in the result
// buffer register. The two line stores share one 4096 x 32 memory read and
// written once per input word; their contents are undefined after reset and
// need no clearing, so words are accepted from the first cycle after reset. The
// user must write size registers only while the core is idle (the core does not
// enforce this); a position outside a new size restarts at row 0, column 0.
`default_nettype none

module local_mean_threshold_3x3_core (
   input  logic                    clock,
   input  logic                    reset,
   // input pixel words
   input  logic                    req_valid,
   output logic                    req_stall,
   input  lmt3_pkg::pix_type       req_pixel,
   // result words
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_above_mean,
   output lmt3_pkg::row_type       rsp_out_row,
   output lmt3_pkg::col_type       rsp_out_col,
   output logic                    rsp_run_last,
   output logic                    rsp_frame_done,
   // register writes
   input  logic                    csr_wr_en,
   input  lmt3_pkg::csr_index_type csr_index,
   input  lmt3_pkg::size_type      csr_wr_data
);

   // size registers, kept as size minus one
   lmt3_pkg::col_type width_m1_ff;
   lmt3_pkg::row_type height_m1_ff;

   // position of the next input word
   lmt3_pkg::row_type pos_row_ff, pos_row_in;
   lmt3_pkg::col_type pos_col_ff, pos_col_in;
   lmt3_pkg::row_type cur_row;
   lmt3_pkg::col_type cur_col;

   // input stage
   logic                    a_valid_ff, a_valid_in;
   lmt3_pkg::pix_type       a_pix_ff;
   lmt3_pkg::row_type       a_row_ff;
   lmt3_pkg::col_type       a_col_ff;
   logic                    byp_sel_ff;
   lmt3_pkg::line_word_type byp_data_ff;

   // line store memory
   lmt3_pkg::line_word_type line_mem [lmt3_pkg::MAX_WIDTH];
   lmt3_pkg::line_word_type mem_rd_ff;
   lmt3_pkg::line_word_type line_rd;
   lmt3_pkg::line_word_type line_wr;

   // sliding window columns c-2 and c-1
   lmt3_pkg::col3_type wcol0_ff;
   lmt3_pkg::col3_type wcol1_ff;
   lmt3_pkg::col3_type wcol2;
   lmt3_pkg::win_type  win;

   // result candidates and buffer
   logic                  r_ge1, r_ge2, c_ge1, c_ge2, c_last, r_last;
   logic [3:0]            cand_ok;
   lmt3_pkg::res_vec_type cand;
   lmt3_pkg::res_vec_type packed_res;
   lmt3_pkg::res_cnt_type packed_cnt;
   lmt3_pkg::res_vec_type buf_ff, buf_in;
   lmt3_pkg::res_cnt_type buf_cnt_ff, buf_cnt_in;

   // handshake
   logic accept;
   logic take;
   logic buf_free;
   logic a_adv;

   assign rsp_valid = buf_cnt_ff != '0;
   assign take      = rsp_valid && !rsp_stall;
   assign buf_free  = (buf_cnt_ff == '0) ||
                      (buf_cnt_ff == lmt3_pkg::res_cnt_type'(1) && !rsp_stall);
   assign a_adv     = a_valid_ff && buf_free;
   assign req_stall = a_valid_ff && !buf_free;
   assign accept    = req_valid && !req_stall;

   // size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_m1_ff  <= lmt3_pkg::WIDTH_M1_RESET;
         height_m1_ff <= lmt3_pkg::HEIGHT_M1_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            lmt3_pkg::REG_IMAGE_WIDTH: begin
               width_m1_ff <= lmt3_pkg::col_type'(
                  lmt3_pkg::size_m1(csr_wr_data, lmt3_pkg::MAX_WIDTH_SIZE));
            end
            lmt3_pkg::REG_IMAGE_HEIGHT: begin
               height_m1_ff <= lmt3_pkg::row_type'(
                  lmt3_pkg::size_m1(csr_wr_data, lmt3_pkg::MAX_HEIGHT_SIZE));
            end
            default: begin
            end
         endcase
      end
   end

   // position of the arriving word, restarted when outside the frame
   always_comb begin
      if ((pos_col_ff > width_m1_ff) || (pos_row_ff > height_m1_ff)) begin
         cur_row = '0;
         cur_col = '0;
      end else begin
         cur_row = pos_row_ff;
         cur_col = pos_col_ff;
      end
      if (cur_col == width_m1_ff) begin
         pos_col_in = '0;
         if (cur_row == height_m1_ff) begin
            pos_row_in = '0;
         end else begin
            pos_row_in = lmt3_pkg::row_type'(cur_row + lmt3_pkg::row_type'(1));
         end
      end else begin
         pos_col_in = lmt3_pkg::col_type'(cur_col + lmt3_pkg::col_type'(1));
         pos_row_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_row_ff <= '0;
         pos_col_ff <= '0;
      end else if (accept) begin
         pos_row_ff <= pos_row_in;
         pos_col_ff <= pos_col_in;
      end
   end

   // input stage occupancy
   always_comb begin
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (a_adv) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   // input stage payload, with forwarding of a same-column write (width one)
   always_ff @(posedge clock) begin
      if (accept) begin
         a_pix_ff    <= req_pixel[lmt3_pkg::PIXEL_BITS-1:0];
         a_row_ff    <= cur_row;
         a_col_ff    <= cur_col;
         byp_sel_ff  <= a_adv && (a_col_ff == cur_col);
         byp_data_ff <= line_wr;
      end
   end

   // line store read at the arriving column
   always_ff @(posedge clock) begin
      if (accept) begin
         mem_rd_ff <= line_mem[cur_col];
      end
   end

   // line store update: row r-1 moves up, the new sample becomes row r-1
   always_ff @(posedge clock) begin
      if (a_adv) begin
         line_mem[a_col_ff] <= line_wr;
      end
   end

   assign line_rd = byp_sel_ff ? byp_data_ff : mem_rd_ff;
   assign line_wr = {line_rd[lmt3_pkg::PIXEL_BITS-1:0], a_pix_ff};

   // newest window column, index is the row
   assign wcol2[0] = line_rd[2*lmt3_pkg::PIXEL_BITS-1:lmt3_pkg::PIXEL_BITS];
   assign wcol2[1] = line_rd[lmt3_pkg::PIXEL_BITS-1:0];
   assign wcol2[2] = a_pix_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win[i][0] = wcol0_ff[i];
         win[i][1] = wcol1_ff[i];
         win[i][2] = wcol2[i];
      end
   end

   // window shift
   always_ff @(posedge clock) begin
      if (a_adv) begin
         wcol0_ff <= wcol1_ff;
         wcol1_ff <= wcol2;
      end
   end

   // edge flags of the pixel in the input stage
   assign r_ge1  = a_row_ff != '0;
   assign r_ge2  = a_row_ff > lmt3_pkg::row_type'(1);
   assign c_ge1  = a_col_ff != '0;
   assign c_ge2  = a_col_ff > lmt3_pkg::col_type'(1);
   assign c_last = a_col_ff == width_m1_ff;
   assign r_last = a_row_ff == height_m1_ff;

   // which results this word releases, in output order
   assign cand_ok[0] = r_ge1 && c_ge1;
   assign cand_ok[1] = r_ge1 && c_last;
   assign cand_ok[2] = r_last && c_ge1;
   assign cand_ok[3] = r_last && c_last;

   // candidate results: above row left, above row end, this row left, this row end
   always_comb begin
      cand[0].above_mean = lmt3_pkg::judge(win, {1'b1, 1'b1, r_ge2},
                                           {1'b1, 1'b1, c_ge2}, 2'd1, 2'd1);
      cand[0].out_row    = lmt3_pkg::row_type'(a_row_ff - lmt3_pkg::row_type'(1));
      cand[0].out_col    = lmt3_pkg::col_type'(a_col_ff - lmt3_pkg::col_type'(1));
      cand[0].run_last   = cand_ok[0] && !cand_ok[1] && !cand_ok[2] && !cand_ok[3];
      cand[0].frame_done = 1'b0;

      cand[1].above_mean = lmt3_pkg::judge(win, {1'b1, 1'b1, r_ge2},
                                           {1'b1, c_ge1, 1'b0}, 2'd1, 2'd2);
      cand[1].out_row    = lmt3_pkg::row_type'(a_row_ff - lmt3_pkg::row_type'(1));
      cand[1].out_col    = a_col_ff;
      cand[1].run_last   = cand_ok[1] && !cand_ok[2] && !cand_ok[3];
      cand[1].frame_done = 1'b0;

      cand[2].above_mean = lmt3_pkg::judge(win, {1'b1, r_ge1, 1'b0},
                                           {1'b1, 1'b1, c_ge2}, 2'd2, 2'd1);
      cand[2].out_row    = a_row_ff;
      cand[2].out_col    = lmt3_pkg::col_type'(a_col_ff - lmt3_pkg::col_type'(1));
      cand[2].run_last   = cand_ok[2] && !cand_ok[3];
      cand[2].frame_done = 1'b0;

      cand[3].above_mean = lmt3_pkg::judge(win, {1'b1, r_ge1, 1'b0},
                                           {1'b1, c_ge1, 1'b0}, 2'd2, 2'd2);
      cand[3].out_row    = a_row_ff;
      cand[3].out_col    = a_col_ff;
      cand[3].run_last   = cand_ok[3];
      cand[3].frame_done = 1'b1;
   end

   // pack the released results to the front
   always_comb begin
      packed_res = '0;
      packed_cnt = '0;
      for (int k = 0; k < lmt3_pkg::RES_MAX; k++) begin
         if (cand_ok[k]) begin
            packed_res[packed_cnt[lmt3_pkg::RES_IDX_BITS-1:0]] = cand[k];
            packed_cnt = lmt3_pkg::res_cnt_type'(packed_cnt + lmt3_pkg::res_cnt_type'(1));
         end
      end
   end

   // result buffer: load a new group or shift out one word
   always_comb begin
      buf_in     = buf_ff;
      buf_cnt_in = buf_cnt_ff;
      if (a_adv) begin
         buf_in     = packed_res;
         buf_cnt_in = packed_cnt;
      end else if (take) begin
         for (int k = 0; k < lmt3_pkg::RES_MAX - 1; k++) begin
            buf_in[k] = buf_ff[k+1];
         end
         buf_cnt_in = lmt3_pkg::res_cnt_type'(buf_cnt_ff - lmt3_pkg::res_cnt_type'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_cnt_ff <= '0;
      end else begin
         buf_cnt_ff <= buf_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   // result word outputs
   assign rsp_above_mean = buf_ff[0].above_mean;
   assign rsp_out_row    = buf_ff[0].out_row;
   assign rsp_out_col    = buf_ff[0].out_col;
   assign rsp_run_last   = buf_ff[0].run_last;
   assign rsp_frame_done = buf_ff[0].frame_done;

endmodule

`default_nettype wire

>>> sv/lmt3_checker.sv
// port-level checker of the local mean threshold core and its bind
`default_nettype none

`include "local_mean_threshold_3x3_core_defines.svh"

module lmt3_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_above_mean,
   input lmt3_pkg::row_type rsp_out_row,
   input lmt3_pkg::col_type rsp_out_col,
   input logic              rsp_run_last,
   input logic              rsp_frame_done
);

   // result word as one vector and the handshake states it is checked in
   lmt3_pkg::res_type rsp_word;
   logic              rsp_held;
   logic              rsp_mid;
   logic              rsp_done;

   assign rsp_word = {rsp_above_mean, rsp_out_row, rsp_out_col, rsp_run_last, rsp_frame_done};
   assign rsp_held = rsp_valid && rsp_stall;
   assign rsp_mid  = rsp_valid && !rsp_stall && !rsp_run_last;
   assign rsp_done = rsp_valid && rsp_frame_done;

   // a stalled result word stays and holds its payload
   `LMT3_ASSERT_NEXT(a_hold_valid, clock, reset, rsp_held, rsp_valid, "stalled word dropped")
   `LMT3_ASSERT_NEXT(a_hold_word, clock, reset, rsp_held, $stable(rsp_word), "held word changed")

   // the frame's final result always closes its run
   `LMT3_ASSERT_SAME(a_done_last, clock, reset, rsp_done, rsp_run_last, "frame end not run end")

   // a run continues without a gap until its last word
   `LMT3_ASSERT_NEXT(a_run_gapless, clock, reset, rsp_mid, rsp_valid, "gap inside a result run")

   // input only stalls while results are waiting
   `LMT3_ASSERT_SAME(a_stall_cause, clock, reset, req_stall, rsp_valid, "stall with no result")

endmodule

bind local_mean_threshold_3x3_core lmt3_checker u_lmt3_checker (.*);

`default_nettype wire
